/* rtl/core/psq_pkg.sv */
// ----------------------------------------------------------------------------
// psq_pkg
// types and constants shared by the polynomial square pipeline
// ----------------------------------------------------------------------------
package psq_pkg;

  localparam int unsigned COEF_W = 32;
  localparam int unsigned PROD_W = 2 * COEF_W;
  localparam int unsigned SUM_W  = PROD_W + 2;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned ORDER_W = 3;

  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [ORDER_W-1:0] order_t;

  // order codes: number of coefficients in use
  localparam order_t ORDER_CONST = 3'd1;
  localparam order_t ORDER_LIN   = 3'd2;
  localparam order_t ORDER_QUAD  = 3'd3;
  localparam order_t ORDER_CUBIC = 3'd4;

  localparam coef_t Q_MAX = 32'sh7FFF_FFFF;
  localparam coef_t Q_MIN = 32'sh8000_0000;

  typedef struct packed {
    coef_t coef_0;
    coef_t coef_1;
    coef_t coef_2;
    coef_t coef_3;
  } in_item_t;

  typedef struct packed {
    prod_t  p00;
    prod_t  p01;
    prod_t  p02;
    prod_t  p11;
    prod_t  p12;
    prod_t  p03;
    order_t order;
  } prod_set_t;

  typedef struct packed {
    coef_t  sq_0;
    coef_t  sq_1;
    coef_t  sq_2;
    coef_t  sq_3;
    order_t order_out;
  } out_item_t;

endpackage

/* rtl/core/psq_if.sv */
// ----------------------------------------------------------------------------
// psq channel interfaces
// valid/ready channels for coefficient items and square items
// ----------------------------------------------------------------------------
interface psq_in_if;
  logic           valid;
  logic           ready;
  psq_pkg::coef_t coef_0;
  psq_pkg::coef_t coef_1;
  psq_pkg::coef_t coef_2;
  psq_pkg::coef_t coef_3;

  modport source (output valid, coef_0, coef_1, coef_2, coef_3, input ready);
  modport sink   (input valid, coef_0, coef_1, coef_2, coef_3, output ready);
endinterface

interface psq_out_if;
  logic            valid;
  logic            ready;
  psq_pkg::coef_t  sq_0;
  psq_pkg::coef_t  sq_1;
  psq_pkg::coef_t  sq_2;
  psq_pkg::coef_t  sq_3;
  psq_pkg::order_t order_out;

  modport source (output valid, sq_0, sq_1, sq_2, sq_3, order_out, input ready);
  modport sink   (input valid, sq_0, sq_1, sq_2, sq_3, order_out, output ready);
endinterface

/* rtl/core/poly_square_qss.sv */
// ----------------------------------------------------------------------------
// poly_square_qss
// square of a cubic Taylor polynomial, truncated to cubic terms
// pipeline: input reg, then product and result regs
// throughput: one item per cycle while the result side keeps ready high;
// every stage advances in the same cycle whenever the result side takes the
// item ahead of it
// reset: order register returns to 1, all pipeline stages empty
// ----------------------------------------------------------------------------
module poly_square_qss (
  input  logic       clk,
  input  logic       rst,
  psq_in_if.sink     coefs,
  psq_out_if.source  squares
);

  // sticky order, tracks the highest nonzero coefficient seen so far
  psq_pkg::order_t active_order;
  psq_pkg::order_t active_order_next;

  // stage valids
  logic v0, v1, v2;
  logic en0, en1, en2;
  logic accept;

  // input register
  psq_pkg::in_item_t  s0;
  psq_pkg::order_t    s0_order;

  psq_pkg::prod_set_t prods;
  psq_pkg::out_item_t result;

  // each stage moves when the one after it has room, bubbles collapse
  assign en2    = !v2 || squares.ready;
  assign en1    = !v1 || en2;
  assign en0    = !v0 || en1;
  assign accept = coefs.valid && en0;
  assign coefs.ready = en0;

  // order only rises: one past the highest nonzero coefficient
  always_comb begin
    active_order_next = active_order;
    if (coefs.coef_1 != '0 && active_order_next < psq_pkg::ORDER_LIN) begin
      active_order_next = psq_pkg::ORDER_LIN;
    end
    if (coefs.coef_2 != '0 && active_order_next < psq_pkg::ORDER_QUAD) begin
      active_order_next = psq_pkg::ORDER_QUAD;
    end
    if (coefs.coef_3 != '0 && active_order_next < psq_pkg::ORDER_CUBIC) begin
      active_order_next = psq_pkg::ORDER_CUBIC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_order <= psq_pkg::ORDER_CONST;
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (accept) begin
        active_order <= active_order_next;
      end
      if (en0) begin
        v0 <= coefs.valid;
      end
      if (en1) begin
        v1 <= v0;
      end
      if (en2) begin
        v2 <= v1;
      end
    end
  end

  // coefficient payload, no reset needed
  always_ff @(posedge clk) begin
    if (en0) begin
      s0.coef_0 <= coefs.coef_0;
      s0.coef_1 <= coefs.coef_1;
      s0.coef_2 <= coefs.coef_2;
      s0.coef_3 <= coefs.coef_3;
      s0_order  <= active_order_next;
    end
  end

  // coefficients above the order are already zero, so no input masking
  psq_mul u_mul (
    .clk   (clk),
    .en    (en1),
    .coefs (s0),
    .order (s0_order),
    .prods (prods)
  );

  // output masking by order happens here
  psq_sum u_sum (
    .clk    (clk),
    .en     (en2),
    .prods  (prods),
    .result (result)
  );

  assign squares.valid     = v2;
  assign squares.sq_0      = result.sq_0;
  assign squares.sq_1      = result.sq_1;
  assign squares.sq_2      = result.sq_2;
  assign squares.sq_3      = result.sq_3;
  assign squares.order_out = result.order_out;

endmodule

/* rtl/core/psq_mul.sv */
// ----------------------------------------------------------------------------
// psq_mul
// product stage: the six 32x32 signed cross products, registered
// ----------------------------------------------------------------------------
module psq_mul (
  input  logic                clk,
  input  logic                en,
  input  psq_pkg::in_item_t   coefs,
  input  psq_pkg::order_t     order,
  output psq_pkg::prod_set_t  prods
);

  function automatic psq_pkg::prod_t mul(input psq_pkg::coef_t a, input psq_pkg::coef_t b);
    mul = psq_pkg::PROD_W'(a) * psq_pkg::PROD_W'(b);
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      prods.p00   <= mul(coefs.coef_0, coefs.coef_0);
      prods.p01   <= mul(coefs.coef_0, coefs.coef_1);
      prods.p02   <= mul(coefs.coef_0, coefs.coef_2);
      prods.p11   <= mul(coefs.coef_1, coefs.coef_1);
      prods.p12   <= mul(coefs.coef_1, coefs.coef_2);
      prods.p03   <= mul(coefs.coef_0, coefs.coef_3);
      prods.order <= order;
    end
  end

endmodule

/* rtl/core/psq_sum.sv */
// ----------------------------------------------------------------------------
// psq_sum
// sum stage: weighted sums, floor to Q16.16, saturate, mask by order
// ----------------------------------------------------------------------------
module psq_sum (
  input  logic                clk,
  input  logic                en,
  input  psq_pkg::prod_set_t  prods,
  output psq_pkg::out_item_t  result
);

  typedef logic signed [psq_pkg::SUM_W-1:0] sum_t;
  localparam int unsigned SHIFT_W = psq_pkg::SUM_W - psq_pkg::FRAC_BITS;

  function automatic sum_t ext(input psq_pkg::prod_t p);
    ext = psq_pkg::SUM_W'(p);
  endfunction

  // floor shift then clamp to 32 bits
  function automatic psq_pkg::coef_t sat(input sum_t s);
    logic signed [SHIFT_W-1:0]           t;
    logic [SHIFT_W-psq_pkg::COEF_W:0]    top;
    t   = SHIFT_W'(s >>> psq_pkg::FRAC_BITS);
    top = t[SHIFT_W-1:psq_pkg::COEF_W-1];
    if ((&top) || !(|top)) begin
      sat = t[psq_pkg::COEF_W-1:0];
    end else if (t[SHIFT_W-1]) begin
      sat = psq_pkg::Q_MIN;
    end else begin
      sat = psq_pkg::Q_MAX;
    end
  endfunction

  sum_t s0, s1, s2, s3;

  always_comb begin
    s0 = ext(prods.p00);
    s1 = ext(prods.p01) <<< 1;
    s2 = (ext(prods.p02) <<< 1) + ext(prods.p11);
    s3 = (ext(prods.p12) <<< 1) + (ext(prods.p03) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.sq_0      <= sat(s0);
      result.sq_1      <= (prods.order >= psq_pkg::ORDER_LIN)   ? sat(s1) : '0;
      result.sq_2      <= (prods.order >= psq_pkg::ORDER_QUAD)  ? sat(s2) : '0;
      result.sq_3      <= (prods.order >= psq_pkg::ORDER_CUBIC) ? sat(s3) : '0;
      result.order_out <= prods.order;
    end
  end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for poly_square_qss: coefficient items go in through a
// valid/ready channel with random gaps, and every square item that comes out
// is compared field by field with a bit-exact predictor of the fixed point
// square and the sticky order register
// ----------------------------------------------------------------------------
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  // worst case is roughly 2000 items with random gaps, so this is far out
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1850;

  logic clk;
  logic rst;

  psq_in_if  coefs_bus ();
  psq_out_if squares_bus ();

  poly_square_qss uut (
    .clk     (clk),
    .rst     (rst),
    .coefs   (coefs_bus.sink),
    .squares (squares_bus.source)
  );

  // predictor state: own copy of the order register
  psq_pkg::order_t held_order;

  // squares still owed by the block, oldest first
  psq_pkg::out_item_t pending_squares[$];

  int error_count = 0;
  int cycle_count = 0;

  // when set, that side runs back to back with no idle cycles
  bit steady_src;
  bit steady_snk;

  // --------------------------------------------------------------------------
  // clock and cycle limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      // a hung handshake or a lost result ends up here
      $display("tb_top: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // predictor
  // --------------------------------------------------------------------------

  // exact sum of Q32.32 products, floored to Q16.16 and clamped to 32 bits
  function automatic psq_pkg::coef_t q16_floor_sat(input logic signed [79:0] acc);
    logic signed [79:0] shifted;
    shifted = acc >>> psq_pkg::FRAC_BITS;
    if (shifted > psq_pkg::Q_MAX) return psq_pkg::Q_MAX;
    if (shifted < psq_pkg::Q_MIN) return psq_pkg::Q_MIN;
    return shifted[psq_pkg::COEF_W-1:0];
  endfunction

  // updates held_order, then squares the polynomial with unused terms cleared
  function automatic psq_pkg::out_item_t predict_square(input psq_pkg::in_item_t c);
    logic signed [79:0] x0, x1, x2, x3;
    psq_pkg::order_t ord;
    psq_pkg::out_item_t sq;
    ord = held_order;
    // a nonzero coefficient lifts the order even past zero lower ones
    if (c.coef_1 != 0 && ord < psq_pkg::ORDER_LIN)   ord = psq_pkg::ORDER_LIN;
    if (c.coef_2 != 0 && ord < psq_pkg::ORDER_QUAD)  ord = psq_pkg::ORDER_QUAD;
    if (c.coef_3 != 0 && ord < psq_pkg::ORDER_CUBIC) ord = psq_pkg::ORDER_CUBIC;
    held_order = ord;

    // coefficients at or above the order count as zero
    x0 = c.coef_0;
    x1 = 0;
    x2 = 0;
    x3 = 0;
    if (ord >= psq_pkg::ORDER_LIN)   x1 = c.coef_1;
    if (ord >= psq_pkg::ORDER_QUAD)  x2 = c.coef_2;
    if (ord >= psq_pkg::ORDER_CUBIC) x3 = c.coef_3;

    sq.sq_0 = q16_floor_sat(x0 * x0);
    sq.sq_1 = '0;
    sq.sq_2 = '0;
    sq.sq_3 = '0;
    if (ord >= psq_pkg::ORDER_LIN)   sq.sq_1 = q16_floor_sat(2 * x0 * x1);
    if (ord >= psq_pkg::ORDER_QUAD)  sq.sq_2 = q16_floor_sat(2 * x0 * x2 + x1 * x1);
    if (ord >= psq_pkg::ORDER_CUBIC) sq.sq_3 = q16_floor_sat(2 * x1 * x2 + 2 * x0 * x3);
    sq.order_out = ord;
    return sq;
  endfunction

  // --------------------------------------------------------------------------
  // checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch @%0t: %s", $realtime, msg);
  endtask

  // sample at the falling edge: values are settled and equal to what the
  // next rising edge will accept
  always @(negedge clk) begin
    psq_pkg::out_item_t want;
    if (!rst && squares_bus.valid && squares_bus.ready) begin
      if (pending_squares.size() == 0) begin
        report_mismatch($sformatf("unexpected square item, order_out %0d",
                                  squares_bus.order_out));
      end else begin
        want = pending_squares.pop_front();
        if (squares_bus.sq_0 !== want.sq_0)
          report_mismatch($sformatf("sq_0 got %0d expected %0d",
                                    squares_bus.sq_0, want.sq_0));
        if (squares_bus.sq_1 !== want.sq_1)
          report_mismatch($sformatf("sq_1 got %0d expected %0d",
                                    squares_bus.sq_1, want.sq_1));
        if (squares_bus.sq_2 !== want.sq_2)
          report_mismatch($sformatf("sq_2 got %0d expected %0d",
                                    squares_bus.sq_2, want.sq_2));
        if (squares_bus.sq_3 !== want.sq_3)
          report_mismatch($sformatf("sq_3 got %0d expected %0d",
                                    squares_bus.sq_3, want.sq_3));
        if (squares_bus.order_out !== want.order_out)
          report_mismatch($sformatf("order_out got %0d expected %0d",
                                    squares_bus.order_out, want.order_out));
      end
    end
  end

  // --------------------------------------------------------------------------
  // result side: random stall before taking each item
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    bit got;
    squares_bus.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = steady_snk ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        squares_bus.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      squares_bus.ready <= 1'b1;
      // ready stays high until one item has been taken
      do begin
        @(negedge clk);
        got = squares_bus.valid;
        @(posedge clk);
      end while (!got);
    end
  end

  // --------------------------------------------------------------------------
  // input side
  // --------------------------------------------------------------------------

  // sends one coefficient item; returns at the edge where it was taken with
  // valid still high, so a back to back item needs no extra edge
  task automatic send_coefs(input psq_pkg::coef_t c0, input psq_pkg::coef_t c1,
                            input psq_pkg::coef_t c2, input psq_pkg::coef_t c3);
    int gap;
    bit taken;
    psq_pkg::in_item_t item;
    gap = steady_src ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      coefs_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    coefs_bus.valid  <= 1'b1;
    coefs_bus.coef_0 <= c0;
    coefs_bus.coef_1 <= c1;
    coefs_bus.coef_2 <= c2;
    coefs_bus.coef_3 <= c3;
    item = '{coef_0: c0, coef_1: c1, coef_2: c2, coef_3: c3};
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = coefs_bus.ready;
      // ready seen high with valid up means the next edge takes the item
      if (taken) pending_squares.push_back(predict_square(item));
      @(posedge clk);
    end
  endtask

  // stop sending and hold until every owed square has come back
  task automatic drain_squares();
    coefs_bus.valid <= 1'b0;
    while (pending_squares.size() != 0) @(posedge clk);
  endtask

  // mix of zeros, extremes, small fixed point values and raw random words
  function automatic psq_pkg::coef_t draw_coef();
    psq_pkg::coef_t v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = psq_pkg::Q_MAX;
      2: v = psq_pkg::Q_MIN;
      3: v = psq_pkg::coef_t'($signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000);
      4: v = $urandom_range(0, 1) ? 32'sd1 : -32'sd1;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // order stays at one: only c0 matters, square never negative
  task automatic test_constant_order();
    send_coefs(32'sh0000_0000, '0, '0, '0);
    send_coefs(32'sh0000_0001, '0, '0, '0);   // tiny, floors to zero
    send_coefs(-32'sh0000_0001, '0, '0, '0);
    send_coefs(32'sh0001_0000, '0, '0, '0);   // 1.0
    send_coefs(-32'sh0001_0000, '0, '0, '0);
    send_coefs(32'sh00B5_0000, '0, '0, '0);   // 181.0, just inside range
    send_coefs(32'sh00B5_04F4, '0, '0, '0);   // just past sqrt of the max
    send_coefs(psq_pkg::Q_MAX, '0, '0, '0);
    send_coefs(psq_pkg::Q_MIN, '0, '0, '0);
    drain_squares();
  endtask

  // first nonzero c1 lifts the order to two; sq_2 and sq_3 stay zero
  task automatic test_linear_order();
    send_coefs(32'sh0003_0000, 32'sh0000_8000, '0, '0);
    send_coefs(-32'sh0000_0001, 32'sh0000_0001, '0, '0);  // floor of a negative
    send_coefs(psq_pkg::Q_MAX, psq_pkg::Q_MAX, '0, '0);   // clamps high
    send_coefs(psq_pkg::Q_MAX, psq_pkg::Q_MIN, '0, '0);   // clamps low
    send_coefs(psq_pkg::Q_MIN, psq_pkg::Q_MIN, '0, '0);
    send_coefs(32'sh0002_0000, '0, '0, '0);               // order does not fall
    drain_squares();
  endtask

  // c2 lifts the order to three while c1 is zero
  task automatic test_quad_order();
    send_coefs(32'sh0001_8000, '0, 32'sh0000_4000, '0);
    // largest sum, clamps
    send_coefs(psq_pkg::Q_MIN, psq_pkg::Q_MIN, psq_pkg::Q_MIN, '0);
    send_coefs(32'sh0000_0001, 32'sh0000_0001, -32'sh0000_0001, '0);
    send_coefs('0, psq_pkg::Q_MAX, '0, '0);
    drain_squares();
  endtask

  // c3 lifts the order to four with c1 and c2 both zero
  task automatic test_cubic_order();
    send_coefs(32'sh0002_0000, '0, '0, -32'sh0000_C000);
    send_coefs(psq_pkg::Q_MIN, psq_pkg::Q_MIN, psq_pkg::Q_MIN, psq_pkg::Q_MIN);
    send_coefs(psq_pkg::Q_MAX, psq_pkg::Q_MAX, psq_pkg::Q_MAX, psq_pkg::Q_MAX);
    // terms partly cancel
    send_coefs(psq_pkg::Q_MIN, psq_pkg::Q_MAX, psq_pkg::Q_MAX, psq_pkg::Q_MAX);
    drain_squares();
  endtask

  // long random stream with steady stretches on either side
  task automatic test_random_stream();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if ($urandom_range(0, 119) == 0) steady_src = !steady_src;
      if ($urandom_range(0, 119) == 0) steady_snk = !steady_snk;
      // one mid-run pause until the pipeline is empty
      if (i == RANDOM_ITEMS / 2) drain_squares();
      send_coefs(draw_coef(), draw_coef(), draw_coef(), draw_coef());
    end
    drain_squares();
  endtask

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst <= 1'b1;
    coefs_bus.valid  <= 1'b0;
    coefs_bus.coef_0 <= '0;
    coefs_bus.coef_1 <= '0;
    coefs_bus.coef_2 <= '0;
    coefs_bus.coef_3 <= '0;
    held_order  = psq_pkg::ORDER_CONST;
    steady_src  = 1'b0;
    steady_snk  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_constant_order();
    test_linear_order();
    test_quad_order();
    test_cubic_order();
    test_random_stream();

    // idle wait after the last drain to catch stray items
    repeat (12) @(posedge clk);
    if (error_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule
